[hdl/imutaf_pkg.sv]
`default_nettype none
package imutaf_pkg;

    localparam int ANGLE_ACC_BITS = 48;
    localparam int CORDIC_STEPS   = 16;
    localparam int NSTEP          = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    localparam int FIELD_W    = 16;
    localparam int IN_TDATA_W = 8 * FIELD_W;
    localparam int OUT_TDATA_W = 216;
    localparam int CFG_IDX_W  = 3;

    localparam int CORD_W  = 28;
    localparam int ANG_W   = 26;
    localparam int DIV_W   = 46;
    localparam int REM_W   = 14;
    localparam int MUL_W   = 32;
    localparam int BLEND_W = 66;
    localparam int SUM_W   = ((ANGLE_ACC_BITS > DIV_W + 1) ? ANGLE_ACC_BITS : DIV_W + 1) + 1;
    localparam int CNT_W   = 6;

    localparam logic [REM_W-1:0] DEN_RATE  = 14'd16375;
    localparam logic [REM_W-1:0] DEN_TEMP  = 14'd340;
    localparam logic [REM_W-1:0] HALF_RATE = 14'd8187;
    localparam logic [REM_W-1:0] HALF_TEMP = 14'd170;

    localparam logic signed [16:0]      TEMP_BIAS = 17'sd12412;
    localparam logic signed [ANG_W-1:0] DEG_90    = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG_180   = 26'sd11796480;

    localparam logic [15:0] GYRO_WEIGHT_RST  = 16'd32113;
    localparam logic [15:0] ACCEL_WEIGHT_RST = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_WEIGHT  = 3'd0,
        REG_ACCEL_WEIGHT = 3'd1,
        REG_OFFSET_X     = 3'd2,
        REG_OFFSET_Y     = 3'd3,
        REG_OFFSET_Z     = 3'd4
    } reg_idx_t;

    // Q16.16 degrees, atan(2^-i)
    function automatic logic [23:0] atan_q16(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            5'd20: v = 24'd4;
            5'd21: v = 24'd2;
            5'd22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hdl/imu_tilt_angle_fusion.sv]
// channel | dir | signals                   | contents
// s       | in  | s_tvalid s_tready s_tdata | one raw IMU frame
// m       | out | m_tvalid m_tready m_tdata | angles, tilts, rates, temperature
// cfg     | in  | cfg_wr_en cfg_index ...   | weights and gyro offsets
// Each word is worked on by one shared bit-serial divider, a shift-add multiplier and one
// CORDIC stage, run in turn. s_tready is high only while no word is in work.
// A finished word waits in the output register; the next frame is taken meanwhile.
// rst_n clears control state, the gyro offsets and the gyro angle accumulators.
`default_nettype none
module imu_tilt_angle_fusion (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // accel_x, accel_y, accel_z, temp_raw, rate_x, rate_y, rate_z, elapsed_ms
    input  wire logic [imutaf_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // angle_x, angle_y, angle_z, tilt_x, tilt_y, corrected_rate_x/y/z, temp_c, pad
    output logic [imutaf_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [imutaf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [imutaf_pkg::FIELD_W-1:0]     cfg_wdata
);
    import imutaf_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CINIT = 8'b0000_0010,
        ST_CSTEP = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_BLEND = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    localparam int ACC_W = ANGLE_ACC_BITS;
    localparam logic signed [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [BLEND_W-1:0] GLIM = {{(BLEND_W-47){1'b0}}, 1'b1, 46'd0};
    localparam logic signed [BLEND_W-1:0] I32_MAX = {{(BLEND_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [BLEND_W-1:0] I32_MIN = {{(BLEND_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [BLEND_W-1:0] RND_15 = {{(BLEND_W-15){1'b0}}, 1'b1, 14'd0};

    state_t state_reg, state_next;
    logic tsel_reg, tsel_next;
    logic [1:0] axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic div_temp_reg, div_temp_next;
    logic neg_reg, neg_next;
    logic zero_reg, zero_next;
    logic [15:0] w_gyro_reg, w_gyro_next, w_accel_reg, w_accel_next;
    logic signed [15:0] ofs_reg [3];
    logic signed [15:0] ofs_next [3];
    logic signed [ACC_W-1:0] gyro_reg [3];
    logic signed [ACC_W-1:0] gyro_next [3];
    logic m_tvalid_reg, m_tvalid_next;

    logic signed [15:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [15:0] traw_reg, traw_next;
    logic [15:0] ms_reg, ms_next;
    logic signed [16:0] crate_reg [3];
    logic signed [16:0] crate_next [3];
    logic signed [CORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W-1:0] cz_reg, cz_next;
    logic signed [24:0] tilt_reg [2];
    logic signed [24:0] tilt_next [2];
    logic [DIV_W-1:0] num_reg, num_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MUL_W-1:0] mul_reg, mul_next;
    logic signed [16:0] temp_reg, temp_next;
    logic signed [BLEND_W-1:0] bacc_reg, bacc_next;
    logic signed [31:0] angle_reg [2];
    logic signed [31:0] angle_next [2];
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic signed [15:0] ca, cb;
    logic signed [16:0] cb_abs;
    logic signed [17:0] x0, y0;
    logic signed [CORD_W-1:0] xs, ys, dx, dy;
    logic [4:0] sh5;
    logic signed [ANG_W-1:0] atan_s, zc, zres;
    logic signed [16:0] tsum, tmag;
    logic [REM_W-1:0] den;
    logic [REM_W:0] trial;
    logic ge;
    logic signed [16:0] cr_sel, cr_mag;
    logic signed [DIV_W:0] dq, dsig;
    logic signed [SUM_W-1:0] asum, amax, amin;
    logic signed [BLEND_W-1:0] gext, gcl, text, term, bres, zext;
    logic [3:0] sh4;
    logic signed [31:0] angle_z;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        tsel_next     = tsel_reg;
        axis_next     = axis_reg;
        cnt_next      = cnt_reg;
        div_temp_next = div_temp_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        w_gyro_next   = w_gyro_reg;
        w_accel_next  = w_accel_reg;
        ofs_next      = ofs_reg;
        gyro_next     = gyro_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        az_next       = az_reg;
        traw_next     = traw_reg;
        ms_next       = ms_reg;
        crate_next    = crate_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        tilt_next     = tilt_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        mul_next      = mul_reg;
        temp_next     = temp_reg;
        bacc_next     = bacc_reg;
        angle_next    = angle_reg;
        m_tdata_next  = m_tdata_reg;

        // cordic operands
        ca     = tsel_reg ? ax_reg : ay_reg;
        cb     = tsel_reg ? ay_reg : ax_reg;
        cb_abs = cb[15] ? -{cb[15], cb} : {cb[15], cb};
        x0     = {{2{az_reg[15]}}, az_reg} + {cb_abs[16], cb_abs};
        y0     = {{2{ca[15]}}, ca};
        xs     = {{(CORD_W-26){x0[17]}}, x0, 8'd0};
        ys     = {{(CORD_W-26){y0[17]}}, y0, 8'd0};
        sh5    = cnt_reg[4:0];
        dx     = cy_reg >>> sh5;
        dy     = cx_reg >>> sh5;
        atan_s = signed'({{(ANG_W-24){1'b0}}, atan_q16(sh5)});
        zc     = (cz_reg > DEG_180) ? DEG_180 : ((cz_reg < -DEG_180) ? -DEG_180 : cz_reg);
        zres   = zero_reg ? '0 : zc;

        // temperature numerator
        tsum = {traw_reg[15], traw_reg} + TEMP_BIAS;
        tmag = tsum[16] ? -tsum : tsum;

        // shared divider
        den   = div_temp_reg ? DEN_TEMP : DEN_RATE;
        trial = {rem_reg, num_reg[DIV_W-1]};
        ge    = (trial >= {1'b0, den});

        cr_sel = crate_reg[axis_reg];
        cr_mag = cr_sel[16] ? -cr_sel : cr_sel;

        dq   = signed'({1'b0, num_reg});
        dsig = neg_reg ? -dq : dq;
        asum = {{(SUM_W-ACC_W){gyro_reg[axis_reg][ACC_W-1]}}, gyro_reg[axis_reg]}
             + {{(SUM_W-DIV_W-1){dsig[DIV_W]}}, dsig};
        amax = {{(SUM_W-ACC_W){1'b0}}, ACC_MAX};
        amin = {{(SUM_W-ACC_W){1'b1}}, ACC_MIN};

        gext = {{(BLEND_W-ACC_W){gyro_reg[axis_reg][ACC_W-1]}}, gyro_reg[axis_reg]};
        gcl  = (gext > GLIM) ? GLIM : ((gext < -GLIM) ? -GLIM : gext);
        text = {{(BLEND_W-25){tilt_reg[axis_reg[0]][24]}}, tilt_reg[axis_reg[0]]};
        sh4  = cnt_reg[3:0];
        term = (w_gyro_reg[sh4] ? (gcl <<< sh4) : '0)
             + (w_accel_reg[sh4] ? (text <<< sh4) : '0);
        bres = (bacc_reg + RND_15) >>> 15;

        zext    = {{(BLEND_W-ACC_W){gyro_reg[2][ACC_W-1]}}, gyro_reg[2]};
        angle_z = (zext > I32_MAX) ? 32'sh7fff_ffff :
                  ((zext < I32_MIN) ? 32'sh8000_0000 : zext[31:0]);

        if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_GYRO_WEIGHT:  w_gyro_next  = cfg_wdata;
                REG_ACCEL_WEIGHT: w_accel_next = cfg_wdata;
                REG_OFFSET_X:     ofs_next[0]  = signed'(cfg_wdata);
                REG_OFFSET_Y:     ofs_next[1]  = signed'(cfg_wdata);
                REG_OFFSET_Z:     ofs_next[2]  = signed'(cfg_wdata);
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ax_next   = signed'(s_tdata[15:0]);
                    ay_next   = signed'(s_tdata[31:16]);
                    az_next   = signed'(s_tdata[47:32]);
                    traw_next = signed'(s_tdata[63:48]);
                    for (int k = 0; k < 3; k++)
                    begin
                        crate_next[k] = {s_tdata[16*k+79], s_tdata[16*k+64 +: 16]}
                                      - {ofs_reg[k][15], ofs_reg[k]};
                    end
                    ms_next    = s_tdata[127:112];
                    tsel_next  = 1'b0;
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT:
            begin
                zero_next = (x0 == '0) && (y0 == '0);
                cnt_next  = '0;
                if (xs < 0)
                begin
                    if (ys >= 0)
                    begin
                        cx_next = ys;
                        cy_next = -xs;
                        cz_next = DEG_90;
                    end
                    else
                    begin
                        cx_next = -ys;
                        cy_next = xs;
                        cz_next = -DEG_90;
                    end
                end
                else
                begin
                    cx_next = xs;
                    cy_next = ys;
                    cz_next = '0;
                end
                state_next = ST_CSTEP;
            end
            ST_CSTEP:
            begin
                if (cnt_reg == CNT_W'(NSTEP))
                begin
                    tilt_next[tsel_reg] = tsel_reg ? 25'(-zres) : zres[24:0];
                    if (!tsel_reg)
                    begin
                        tsel_next  = 1'b1;
                        state_next = ST_CINIT;
                    end
                    else
                    begin
                        neg_next      = tsum[16];
                        num_next      = DIV_W'({tmag[15:0], 8'd0}) + DIV_W'(HALF_TEMP);
                        rem_next      = '0;
                        cnt_next      = '0;
                        div_temp_next = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else
                begin
                    if (cy_reg > 0)
                    begin
                        cx_next = cx_reg + dx;
                        cy_next = cy_reg - dy;
                        cz_next = cz_reg + atan_s;
                    end
                    else
                    begin
                        cx_next = cx_reg - dx;
                        cy_next = cy_reg + dy;
                        cz_next = cz_reg - atan_s;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_W))
                begin
                    if (div_temp_reg)
                    begin
                        temp_next  = neg_reg ? -signed'(num_reg[16:0]) : signed'(num_reg[16:0]);
                        axis_next  = 2'd0;
                        mul_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_ACC;
                    end
                end
                else
                begin
                    rem_next = ge ? REM_W'(trial - {1'b0, den}) : trial[REM_W-1:0];
                    num_next = {num_reg[DIV_W-2:0], ge};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(16))
                begin
                    num_next      = {mul_reg, 14'd0} + DIV_W'(HALF_RATE);
                    rem_next      = '0;
                    neg_next      = cr_sel[16];
                    div_temp_next = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    if (ms_reg[sh4])
                    begin
                        mul_next = mul_reg + ({16'd0, cr_mag[15:0]} << sh4);
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ACC:
            begin
                if (asum > amax)
                begin
                    gyro_next[axis_reg] = ACC_MAX;
                end
                else if (asum < amin)
                begin
                    gyro_next[axis_reg] = ACC_MIN;
                end
                else
                begin
                    gyro_next[axis_reg] = asum[ACC_W-1:0];
                end
                cnt_next = '0;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    bacc_next  = '0;
                    state_next = ST_BLEND;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    mul_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_BLEND:
            begin
                if (cnt_reg == CNT_W'(16))
                begin
                    angle_next[axis_reg[0]] = (bres > I32_MAX) ? 32'sh7fff_ffff :
                                              ((bres < I32_MIN) ? 32'sh8000_0000 : bres[31:0]);
                    cnt_next  = '0;
                    bacc_next = '0;
                    if (axis_reg[0])
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next = 2'd1;
                    end
                end
                else
                begin
                    bacc_next = bacc_reg + term;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next = {2'b00, temp_reg, crate_reg[2], crate_reg[1], crate_reg[0],
                                    tilt_reg[1], tilt_reg[0], angle_z,
                                    angle_reg[1], angle_reg[0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tsel_reg     <= 1'b0;
            axis_reg     <= 2'd0;
            cnt_reg      <= '0;
            div_temp_reg <= 1'b0;
            neg_reg      <= 1'b0;
            zero_reg     <= 1'b0;
            w_gyro_reg   <= GYRO_WEIGHT_RST;
            w_accel_reg  <= ACCEL_WEIGHT_RST;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                ofs_reg[k]  <= '0;
                gyro_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            tsel_reg     <= tsel_next;
            axis_reg     <= axis_next;
            cnt_reg      <= cnt_next;
            div_temp_reg <= div_temp_next;
            neg_reg      <= neg_next;
            zero_reg     <= zero_next;
            w_gyro_reg   <= w_gyro_next;
            w_accel_reg  <= w_accel_next;
            m_tvalid_reg <= m_tvalid_next;
            ofs_reg      <= ofs_next;
            gyro_reg     <= gyro_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        az_reg      <= az_next;
        traw_reg    <= traw_next;
        ms_reg      <= ms_next;
        crate_reg   <= crate_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        tilt_reg    <= tilt_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        mul_reg     <= mul_next;
        temp_reg    <= temp_next;
        bacc_reg    <= bacc_next;
        angle_reg   <= angle_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CINIT))
        else $error("accepted word did not start cordic");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(DIV_W)))
        else $error("divider count overrun");

    a_blend_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLEND) |-> (axis_reg <= 2'd1 && cnt_reg <= CNT_W'(16)))
        else $error("blend axis or count out of range");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
        else $error("result not loaded");

endmodule
`default_nettype wire
